/* sv/bcdfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bcdfa_pkg;

  localparam int DIGIT_W     = 4;
  localparam int MANT_DIGITS = 10;
  localparam int WORK_DIGITS = 21;
  localparam int MANT_W      = DIGIT_W * MANT_DIGITS;
  localparam int EXP_W       = 8;   // two packed BCD digits
  localparam int EXPI_W      = 8;   // signed binary exponent, -108..100
  localparam int MAG_W       = 7;
  localparam int EXP_MAX     = 99;

  localparam logic [DIGIT_W-1:0] SIGN_POS = 4'd0;
  localparam logic [DIGIT_W-1:0] SIGN_NEG = 4'd9;

  typedef struct packed {
    logic [DIGIT_W-1:0] a_sign;
    logic [MANT_W-1:0]  a_mantissa;
    logic [EXP_W-1:0]   a_exponent;
    logic [DIGIT_W-1:0] a_exp_sign;
    logic [DIGIT_W-1:0] b_sign;
    logic [MANT_W-1:0]  b_mantissa;
    logic [EXP_W-1:0]   b_exponent;
    logic [DIGIT_W-1:0] b_exp_sign;
  } in_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] sum_sign;
    logic [MANT_W-1:0]  sum_mantissa;
    logic [EXP_W-1:0]   sum_exponent;
    logic [DIGIT_W-1:0] sum_exp_sign;
    logic               exp_overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALIGN,
    ST_SUM,
    ST_FIX,
    ST_RECMP,
    ST_NORM,
    ST_DONE
  } state_t;

  // control for the serial digit unit
  typedef struct packed {
    logic step;     // consume one digit this cycle
    logic first;    // current digit is the least significant one
    logic cmp_x;    // ten's complement the x stream
    logic cmp_y;    // ten's complement the y stream
    logic add_en;   // digit lies in the summed field
  } alu_ctrl_t;

  // non-decimal nibbles read as 9
  function automatic logic [DIGIT_W-1:0] dec_digit(input logic [DIGIT_W-1:0] d);
    dec_digit = (d > 4'd9) ? 4'd9 : d;
  endfunction

  function automatic logic signed [EXPI_W-1:0] exp_to_int(input logic [EXP_W-1:0] e,
                                                          input logic [DIGIT_W-1:0] es);
    logic [MAG_W-1:0] v;
    v = MAG_W'(dec_digit(e[7:4])) * MAG_W'(10) + MAG_W'(dec_digit(e[3:0]));
    exp_to_int = (es != 4'd0) ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  // magnitude 0..99 to two packed BCD digits
  function automatic logic [EXP_W-1:0] mag_to_bcd(input logic [MAG_W-1:0] mag);
    logic [DIGIT_W-1:0] tens;
    logic [MAG_W-1:0]   ones;
    tens = 4'd0;
    for (int t = 1; t < 10; t++) begin
      if (mag >= MAG_W'(10 * t)) begin
        tens = DIGIT_W'(t);
      end
    end
    ones = mag - MAG_W'(tens) * MAG_W'(10);
    mag_to_bcd = {tens, ones[DIGIT_W-1:0]};
  endfunction

endpackage

`default_nettype wire

/* sv/bcdfa_serial_alu.sv */
`timescale 1ns / 1ps
`default_nettype none

// One BCD digit per step, least significant first: optional ten's complement of
// each stream, then an optional decimal add of the two.
module bcdfa_serial_alu (
  input  wire logic                         clk,
  input  wire bcdfa_pkg::alu_ctrl_t         ctrl,
  input  wire logic [bcdfa_pkg::DIGIT_W-1:0] x_dig,
  input  wire logic [bcdfa_pkg::DIGIT_W-1:0] y_dig,
  output logic      [bcdfa_pkg::DIGIT_W-1:0] z_dig,
  output logic                              add_carry
);

  logic cx_r, cy_r, ca_r;
  logic cx_nxt, cy_nxt, ca_nxt;
  logic cin_x, cin_y, cin_a;
  logic [bcdfa_pkg::DIGIT_W:0]   tx, ty, ts;
  logic [bcdfa_pkg::DIGIT_W-1:0] xc, yc, sd;
  logic cxo, cyo, cao;

  assign cin_x = ctrl.first ? 1'b1 : cx_r;
  assign cin_y = ctrl.first ? 1'b1 : cy_r;
  assign cin_a = ctrl.first ? 1'b0 : ca_r;

  always_comb begin
    tx  = 5'd9 - {1'b0, x_dig} + {4'd0, cin_x};
    cxo = (tx > 5'd9);
    xc  = cxo ? 4'd0 : tx[3:0];
    if (!ctrl.cmp_x) begin
      xc = x_dig;
    end

    ty  = 5'd9 - {1'b0, y_dig} + {4'd0, cin_y};
    cyo = (ty > 5'd9);
    yc  = cyo ? 4'd0 : ty[3:0];
    if (!ctrl.cmp_y) begin
      yc = y_dig;
    end

    ts  = {1'b0, xc} + {1'b0, yc} + {4'd0, cin_a};
    cao = (ts > 5'd9);
    sd  = cao ? 4'(ts - 5'd10) : ts[3:0];

    z_dig  = ctrl.add_en ? sd : xc;
    cx_nxt = cxo;
    cy_nxt = cyo;
    ca_nxt = ctrl.add_en & cao;
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      ca_r <= ca_nxt;
    end
  end

  assign add_carry = ca_r;

endmodule

`default_nettype wire

/* sv/bcd_float_adder_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Decimal floating-point adder, one transaction at a time. Operands are loaded
// into two digit shift registers of R = max(WORK_DIGITS, 10) digits; the
// smaller-exponent operand is shifted right one digit per cycle, then a single
// BCD digit unit walks the working register once (complement and add) and, for
// a subtraction without carry, a second time to recomplement; normalizing then
// shifts left one digit per cycle, at most 9 shifts. A finished result sits in
// an output register, so the next transaction is taken while it waits.
module bcd_float_adder_core #(
  parameter int WORK_DIGITS = bcdfa_pkg::WORK_DIGITS
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire bcdfa_pkg::in_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output bcdfa_pkg::out_t      out_data
);

  localparam int M       = bcdfa_pkg::MANT_DIGITS;
  localparam int DW      = bcdfa_pkg::DIGIT_W;
  localparam int REG_LEN = (WORK_DIGITS > M) ? WORK_DIGITS : M;
  localparam int SH_W    = $clog2(REG_LEN + 1);
  localparam int CNT_W   = $clog2(REG_LEN);
  localparam int EW      = bcdfa_pkg::EXPI_W;

  bcdfa_pkg::state_t state_r, state_nxt;

  logic [DW-1:0] x_r [REG_LEN];
  logic [DW-1:0] y_r [REG_LEN];
  logic [DW-1:0] x_nxt [REG_LEN];
  logic [DW-1:0] y_nxt [REG_LEN];
  logic signed [EW-1:0] e_r, e_nxt;
  logic [SH_W-1:0]  sh_r, sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             shx_r, shx_nxt;     // 1: x is the operand being aligned
  logic             sub_r, sub_nxt;
  logic             cmpa_r, cmpa_nxt;
  logic             cmpb_r, cmpb_nxt;
  logic [DW-1:0]    sign_r, sign_nxt;

  logic                 out_valid_r;
  bcdfa_pkg::out_t      out_data_r;

  bcdfa_pkg::alu_ctrl_t alu_ctrl;
  logic [DW-1:0]        alu_z;
  logic                 alu_carry;

  // load-time decode
  logic signed [EW-1:0] ea, eb;
  logic signed [EW:0]   diff, neg_diff;
  logic [EW-1:0]        diff_mag;
  logic [SH_W-1:0]      sh_load;
  logic                 a_neg, b_neg;

  // normalize test and result formatting
  logic                 lower_nz;
  logic                 norm_shift;
  logic                 last_digit;
  logic                 out_load;
  logic [EW-1:0]        e_abs;
  logic [bcdfa_pkg::MAG_W-1:0] mag, mag_sat;
  logic                 ovf;
  logic [bcdfa_pkg::MANT_W-1:0] mant;

  bcdfa_serial_alu u_alu (
    .clk       (clk),
    .ctrl      (alu_ctrl),
    .x_dig     (x_r[REG_LEN-1]),
    .y_dig     (y_r[REG_LEN-1]),
    .z_dig     (alu_z),
    .add_carry (alu_carry)
  );

  always_comb begin
    ea       = bcdfa_pkg::exp_to_int(in_data.a_exponent, in_data.a_exp_sign);
    eb       = bcdfa_pkg::exp_to_int(in_data.b_exponent, in_data.b_exp_sign);
    diff     = {ea[EW-1], ea} - {eb[EW-1], eb};
    neg_diff = -diff;
    diff_mag = diff[EW] ? neg_diff[EW-1:0] : diff[EW-1:0];
    sh_load  = (diff_mag >= EW'(REG_LEN)) ? SH_W'(REG_LEN) : diff_mag[SH_W-1:0];
    a_neg    = (in_data.a_sign != 4'd0);
    b_neg    = (in_data.b_sign != 4'd0);
  end

  always_comb begin
    lower_nz = 1'b0;
    for (int i = 1; i < M; i++) begin
      lower_nz = lower_nz | (x_r[i] != 4'd0);
    end
    norm_shift = (x_r[0] == 4'd0) && lower_nz;
    last_digit = (cnt_r == CNT_W'(REG_LEN - 1));
    out_load   = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bcdfa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bcdfa_pkg::ST_ALIGN;
        end
      end
      bcdfa_pkg::ST_ALIGN: begin
        if (sh_r == '0) begin
          state_nxt = bcdfa_pkg::ST_SUM;
        end
      end
      bcdfa_pkg::ST_SUM: begin
        if (last_digit) begin
          state_nxt = bcdfa_pkg::ST_FIX;
        end
      end
      bcdfa_pkg::ST_FIX: begin
        if (sub_r && !alu_carry) begin
          state_nxt = bcdfa_pkg::ST_RECMP;
        end else begin
          state_nxt = bcdfa_pkg::ST_NORM;
        end
      end
      bcdfa_pkg::ST_RECMP: begin
        if (last_digit) begin
          state_nxt = bcdfa_pkg::ST_NORM;
        end
      end
      bcdfa_pkg::ST_NORM: begin
        if (!norm_shift) begin
          state_nxt = bcdfa_pkg::ST_DONE;
        end
      end
      bcdfa_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = bcdfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bcdfa_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    alu_ctrl = '0;
    unique case (state_r)
      bcdfa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      bcdfa_pkg::ST_SUM: begin
        alu_ctrl.step   = 1'b1;
        alu_ctrl.first  = (cnt_r == '0);
        alu_ctrl.cmp_x  = cmpa_r;
        alu_ctrl.cmp_y  = cmpb_r;
        alu_ctrl.add_en = (cnt_r >= CNT_W'(REG_LEN - M));
      end
      bcdfa_pkg::ST_RECMP: begin
        alu_ctrl.step  = 1'b1;
        alu_ctrl.first = (cnt_r == '0);
        alu_ctrl.cmp_x = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // datapath
  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    e_nxt    = e_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    shx_nxt  = shx_r;
    sub_nxt  = sub_r;
    cmpa_nxt = cmpa_r;
    cmpb_nxt = cmpb_r;
    sign_nxt = sign_r;
    unique case (state_r)
      bcdfa_pkg::ST_IDLE: begin
        for (int i = 0; i < M; i++) begin
          x_nxt[i] = bcdfa_pkg::dec_digit(in_data.a_mantissa[DW*(M-1-i) +: DW]);
          y_nxt[i] = bcdfa_pkg::dec_digit(in_data.b_mantissa[DW*(M-1-i) +: DW]);
        end
        for (int i = M; i < REG_LEN; i++) begin
          x_nxt[i] = '0;
          y_nxt[i] = '0;
        end
        sub_nxt  = a_neg ^ b_neg;
        cmpa_nxt = (a_neg ^ b_neg) & a_neg;
        cmpb_nxt = (a_neg ^ b_neg) & b_neg;
        sign_nxt = in_data.a_sign;
        shx_nxt  = diff[EW];
        sh_nxt   = sh_load;
        e_nxt    = diff[EW] ? eb : ea;
        cnt_nxt  = '0;
      end
      bcdfa_pkg::ST_ALIGN: begin
        if (sh_r != '0) begin
          sh_nxt = sh_r - SH_W'(1);
          if (shx_r) begin
            for (int i = REG_LEN - 1; i > 0; i--) begin
              x_nxt[i] = x_r[i-1];
            end
            x_nxt[0] = '0;
          end else begin
            for (int i = REG_LEN - 1; i > 0; i--) begin
              y_nxt[i] = y_r[i-1];
            end
            y_nxt[0] = '0;
          end
        end
      end
      bcdfa_pkg::ST_SUM, bcdfa_pkg::ST_RECMP: begin
        // rotate: least significant digit out, processed digit in at the top
        for (int i = REG_LEN - 1; i > 0; i--) begin
          x_nxt[i] = x_r[i-1];
          y_nxt[i] = y_r[i-1];
        end
        x_nxt[0] = alu_z;
        y_nxt[0] = y_r[REG_LEN-1];
        cnt_nxt  = last_digit ? '0 : cnt_r + CNT_W'(1);
      end
      bcdfa_pkg::ST_FIX: begin
        if (sub_r) begin
          if (alu_carry) begin
            sign_nxt = bcdfa_pkg::SIGN_POS;
          end else if (sign_r == bcdfa_pkg::SIGN_POS) begin
            sign_nxt = bcdfa_pkg::SIGN_NEG;
          end
        end else if (alu_carry) begin
          for (int i = REG_LEN - 1; i > 0; i--) begin
            x_nxt[i] = x_r[i-1];
          end
          x_nxt[0] = 4'd1;
          e_nxt    = e_r + EW'(1);
        end
      end
      bcdfa_pkg::ST_NORM: begin
        if (norm_shift) begin
          for (int i = 0; i < REG_LEN - 1; i++) begin
            x_nxt[i] = x_r[i+1];
          end
          x_nxt[REG_LEN-1] = '0;
          e_nxt = e_r - EW'(1);
        end
      end
      default: begin
        e_nxt = e_r;
      end
    endcase
  end

  // result formatting
  always_comb begin
    e_abs   = e_r[EW-1] ? EW'(-e_r) : EW'(e_r);
    mag     = e_abs[bcdfa_pkg::MAG_W-1:0];
    ovf     = (mag > bcdfa_pkg::MAG_W'(bcdfa_pkg::EXP_MAX));
    mag_sat = ovf ? bcdfa_pkg::MAG_W'(bcdfa_pkg::EXP_MAX) : mag;
    for (int i = 0; i < M; i++) begin
      mant[DW*(M-1-i) +: DW] = x_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcdfa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bcdfa_pkg::ST_DONE && out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    e_r    <= e_nxt;
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
    shx_r  <= shx_nxt;
    sub_r  <= sub_nxt;
    cmpa_r <= cmpa_nxt;
    cmpb_r <= cmpb_nxt;
    sign_r <= sign_nxt;
    if (state_r == bcdfa_pkg::ST_DONE && out_load) begin
      out_data_r.sum_sign     <= sign_r;
      out_data_r.sum_mantissa <= mant;
      out_data_r.sum_exponent <= bcdfa_pkg::mag_to_bcd(mag_sat);
      out_data_r.sum_exp_sign <= e_r[EW-1] ? bcdfa_pkg::SIGN_NEG : bcdfa_pkg::SIGN_POS;
      out_data_r.exp_overflow <= ovf;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_normalized: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sum_mantissa[bcdfa_pkg::MANT_W-1 -: 4] != 4'd0) ||
                  (out_data.sum_mantissa == '0))
    else $error("result mantissa not normalized");

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.exp_overflow |-> out_data.sum_exponent == 8'h99)
    else $error("exponent overflow without saturation");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bcdfa_pkg::ST_DONE && out_load |=> out_valid)
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

/* test/bcd_float_adder_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, predicts each sum from the accepted operands and
// compares results in order.
module bcd_float_adder_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bcdfa_pkg::in_t     in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bcdfa_pkg::out_t    out_data,
  output int                 fail_count,
  output int                 outstanding
);
  import bcdfa_pkg::*;

  localparam int REG_LEN = (WORK_DIGITS > MANT_DIGITS) ? WORK_DIGITS : MANT_DIGITS;
  localparam int REG_W   = DIGIT_W * REG_LEN;
  localparam int LOW_W   = REG_W - MANT_W;

  // digit 0 (most significant) sits in the top nibble
  typedef logic [REG_W-1:0] work_reg_t;

  out_t sum_q[$];
  out_t want;

  function automatic logic [3:0] clip_digit(input logic [3:0] d);
    return (d > 4'd9) ? 4'd9 : d;
  endfunction

  function automatic int exp_value(input logic [7:0] e, input logic [3:0] es);
    int v;
    v = int'(clip_digit(e[7:4])) * 10 + int'(clip_digit(e[3:0]));
    return (es != 4'd0) ? -v : v;
  endfunction

  function automatic work_reg_t load_digits(input logic [MANT_W-1:0] m);
    work_reg_t r;
    r = '0;
    for (int i = 0; i < MANT_DIGITS; i++) begin
      r[REG_W-1-4*i -: 4] = clip_digit(m[MANT_W-1-4*i -: 4]);
    end
    return r;
  endfunction

  function automatic work_reg_t shift_down(input work_reg_t r, input int k);
    if (k >= REG_LEN) begin
      return '0;
    end
    return r >> (4 * k);
  endfunction

  // ten's complement over the whole working register
  function automatic work_reg_t tens_comp(input work_reg_t r);
    int c;
    int v;
    c = 1;
    for (int j = 0; j < REG_LEN; j++) begin
      v = 9 - int'(r[4*j +: 4]) + c;
      if (v > 9) begin
        v -= 10;
        c = 1;
      end else begin
        c = 0;
      end
      r[4*j +: 4] = v[3:0];
    end
    return r;
  endfunction

  function automatic out_t predict_sum(input in_t op);
    work_reg_t x;
    work_reg_t y;
    logic      a_neg;
    logic      b_neg;
    logic      diff_signs;
    logic      ovf;
    logic [3:0] sgn;
    int        ea;
    int        eb;
    int        carry;
    int        v;
    int        mag;
    out_t      res;
    a_neg = op.a_sign != 4'd0;
    b_neg = op.b_sign != 4'd0;
    diff_signs = a_neg != b_neg;
    sgn = op.a_sign;
    ea = exp_value(op.a_exponent, op.a_exp_sign);
    eb = exp_value(op.b_exponent, op.b_exp_sign);
    x = load_digits(op.a_mantissa);
    y = load_digits(op.b_mantissa);

    if (ea > eb) begin
      y = shift_down(y, ea - eb);
    end else if (eb > ea) begin
      x = shift_down(x, eb - ea);
      ea = eb;
    end

    if (diff_signs) begin
      if (a_neg) x = tens_comp(x);
      if (b_neg) y = tens_comp(y);
    end

    // only the mantissa field is summed; low digits keep x's content
    carry = 0;
    for (int j = 0; j < MANT_DIGITS; j++) begin
      v = int'(x[LOW_W+4*j +: 4]) + int'(y[LOW_W+4*j +: 4]) + carry;
      if (v >= 10) begin
        v -= 10;
        carry = 1;
      end else begin
        carry = 0;
      end
      x[LOW_W+4*j +: 4] = v[3:0];
    end

    if (diff_signs) begin
      if (carry == 0) begin
        x = tens_comp(x);
        if (sgn == SIGN_POS) sgn = SIGN_NEG;
      end else begin
        sgn = SIGN_POS;
      end
    end else if (carry != 0) begin
      x = x >> 4;
      x[REG_W-1 -: 4] = 4'd1;
      ea++;
    end

    // left-normalize unless the mantissa field is all zero
    for (int k = 0; k < MANT_DIGITS; k++) begin
      if (x[REG_W-1 -: 4] != 4'd0) break;
      if (x[REG_W-5 -: MANT_W-4] == '0) break;
      x = x << 4;
      ea--;
    end

    mag = (ea < 0) ? -ea : ea;
    ovf = mag > EXP_MAX;
    if (ovf) mag = EXP_MAX;

    res.sum_sign     = sgn;
    res.sum_mantissa = x[REG_W-1 -: MANT_W];
    res.sum_exponent = {4'(mag / 10), 4'(mag % 10)};
    res.sum_exp_sign = (ea < 0) ? SIGN_NEG : SIGN_POS;
    res.exp_overflow = ovf;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [MANT_W-1:0] exp_val,
                             input logic [MANT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sum_q.delete();
      fail_count = 0;
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sum_q.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          want = sum_q.pop_front();
          check_field("sum_sign", MANT_W'(want.sum_sign), MANT_W'(out_data.sum_sign));
          check_field("sum_mantissa", want.sum_mantissa, out_data.sum_mantissa);
          check_field("sum_exponent", MANT_W'(want.sum_exponent),
                      MANT_W'(out_data.sum_exponent));
          check_field("sum_exp_sign", MANT_W'(want.sum_exp_sign),
                      MANT_W'(out_data.sum_exp_sign));
          check_field("exp_overflow", MANT_W'(want.exp_overflow),
                      MANT_W'(out_data.exp_overflow));
        end
      end
      if (in_valid && in_ready) begin
        sum_q.push_back(predict_sum(in_data));
      end
      outstanding = sum_q.size();
    end
  end

endmodule

/* test/bcd_float_adder_core_test.sv */
`timescale 1ns / 1ps

module bcd_float_adder_core_test;
  import bcdfa_pkg::*;

  localparam int CYCLE_LIMIT  = 500_000;
  localparam int RANDOM_OPS   = 900;
  localparam int DRAIN_CYCLES = 100;
  localparam int IDLE_PCT     = 38;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  in_t  in_data   = '0;
  logic out_ready = 1'b0;
  logic steady    = 1'b0;
  logic in_ready;
  logic out_valid;
  out_t out_data;
  int   fail_count;
  int   outstanding;
  int   cycles = 0;

  always #4 clk = ~clk;

  bcd_float_adder_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  bcd_float_adder_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic in_t operands(input logic [3:0] a_s, input logic [MANT_W-1:0] a_m,
                                   input logic [7:0] a_e, input logic [3:0] a_es,
                                   input logic [3:0] b_s, input logic [MANT_W-1:0] b_m,
                                   input logic [7:0] b_e, input logic [3:0] b_es);
    in_t op;
    op.a_sign = a_s;
    op.a_mantissa = a_m;
    op.a_exponent = a_e;
    op.a_exp_sign = a_es;
    op.b_sign = b_s;
    op.b_mantissa = b_m;
    op.b_exponent = b_e;
    op.b_exp_sign = b_es;
    return op;
  endfunction

  function automatic logic [3:0] rand_sign();
    return ($urandom_range(1) == 1) ? 4'($urandom_range(1, 9)) : SIGN_POS;
  endfunction

  // {bcd magnitude, sign digit} for a signed exponent
  function automatic logic [11:0] exp_fields(input int e);
    int         mag;
    logic [3:0] es;
    mag = (e < 0) ? -e : e;
    if (e < 0) begin
      es = 4'($urandom_range(1, 9));
    end else begin
      es = (e == 0 && $urandom_range(7) == 0) ? SIGN_NEG : SIGN_POS;
    end
    return {4'(mag / 10), 4'(mag % 10), es};
  endfunction

  function automatic logic [MANT_W-1:0] rand_mantissa();
    logic [MANT_W-1:0] m;
    logic [3:0]        d;
    int                mode;
    int                lead;
    m = '0;
    mode = $urandom_range(9);
    lead = (mode == 1) ? $urandom_range(MANT_DIGITS - 1) : 0;
    for (int i = 0; i < MANT_DIGITS; i++) begin
      if (mode == 0 || i < lead) begin
        d = 4'd0;
      end else if (mode == 2) begin
        d = ($urandom_range(4) == 0) ? 4'($urandom_range(1, 9)) : 4'd0;
      end else if (i == lead) begin
        d = 4'($urandom_range(1, 9));
      end else begin
        d = 4'($urandom_range(9));
      end
      m[MANT_W-1-4*i -: 4] = d;
    end
    return m;
  endfunction

  function automatic in_t rand_operands();
    in_t op;
    int  kind;
    int  ea;
    int  eb;
    int  spread;
    int  keep;
    kind = $urandom_range(99);
    if (kind < 10) begin
      // raw fields, non-decimal nibbles included
      op.a_sign = 4'($urandom_range(9));
      op.a_mantissa = MANT_W'({$urandom(), $urandom()});
      op.a_exponent = 8'($urandom_range(153));
      op.a_exp_sign = 4'($urandom_range(9));
      op.b_sign = 4'($urandom_range(9));
      op.b_mantissa = MANT_W'({$urandom(), $urandom()});
      op.b_exponent = 8'($urandom_range(153));
      op.b_exp_sign = 4'($urandom_range(9));
      return op;
    end
    if ($urandom_range(9) == 0) begin
      ea = ($urandom_range(1) == 1) ? int'($urandom_range(90, 99)) :
                                      -int'($urandom_range(90, 99));
    end else begin
      ea = int'($urandom_range(198)) - 99;
    end
    case ($urandom_range(9))
      7, 8:    spread = $urandom_range(12, 25);
      9:       spread = $urandom_range(198);
      default: spread = $urandom_range(11);
    endcase
    eb = ($urandom_range(1) == 1) ? ea + spread : ea - spread;
    if (eb > EXP_MAX) eb = EXP_MAX;
    if (eb < -EXP_MAX) eb = -EXP_MAX;
    op.a_sign = rand_sign();
    op.b_sign = rand_sign();
    op.a_mantissa = rand_mantissa();
    if (kind < 30) begin
      // near cancellation: opposite signs, same exponent, shared top digits
      eb = ea;
      keep = $urandom_range(MANT_DIGITS);
      op.b_mantissa = op.a_mantissa;
      for (int i = keep; i < MANT_DIGITS; i++) begin
        op.b_mantissa[MANT_W-1-4*i -: 4] = 4'($urandom_range(9));
      end
      op.b_sign = (op.a_sign == SIGN_POS) ? 4'($urandom_range(1, 9)) : SIGN_POS;
    end else begin
      op.b_mantissa = rand_mantissa();
    end
    {op.a_exponent, op.a_exp_sign} = exp_fields(ea);
    {op.b_exponent, op.b_exp_sign} = exp_fields(eb);
    return op;
  endfunction

  // called and returns at a falling edge; valid stays up into the next call
  task automatic send_operands(input in_t op);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zeros, plain add, carry into exponent overflow
    send_operands(operands(4'd0, 40'h0, 8'h00, 4'd0, 4'd0, 40'h0, 8'h00, 4'd0));
    send_operands(operands(4'd0, 40'h1000000000, 8'h00, 4'd0,
                           4'd0, 40'h1000000000, 8'h00, 4'd0));
    send_operands(operands(4'd0, 40'h9999999999, 8'h99, 4'd0,
                           4'd0, 40'h9999999999, 8'h99, 4'd0));
    // exact cancellation, negative difference, mixed sign digits
    send_operands(operands(4'd0, 40'h1234567890, 8'h05, 4'd0,
                           4'd9, 40'h1234567890, 8'h05, 4'd0));
    send_operands(operands(4'd0, 40'h1000000000, 8'h00, 4'd0,
                           4'd9, 40'h2000000000, 8'h00, 4'd0));
    send_operands(operands(4'd3, 40'h5000000000, 8'h00, 4'd0,
                           4'd0, 40'h7000000000, 8'h00, 4'd0));
    send_operands(operands(4'd3, 40'h7000000000, 8'h00, 4'd0,
                           4'd0, 40'h5000000000, 8'h00, 4'd0));
    send_operands(operands(4'd5, 40'h6000000000, 8'h02, 4'd0,
                           4'd9, 40'h7000000000, 8'h02, 4'd0));
    // non-decimal nibbles everywhere
    send_operands(operands(4'd0, 40'hFFFFFFFFFF, 8'h5F, 4'd0,
                           4'd0, 40'hABCDEF0123, 8'h3C, 4'd1));
    send_operands(operands(4'd8, 40'hFFFFFFFFFF, 8'h0F, 4'd0,
                           4'd0, 40'hFFFFFFFFFF, 8'h0A, 4'd8));
    // alignment past the register, at its edge, and one digit
    send_operands(operands(4'd0, 40'h5000000000, 8'h50, 4'd0,
                           4'd0, 40'h9999999999, 8'h50, 4'd9));
    send_operands(operands(4'd0, 40'h4000000000, 8'h21, 4'd0,
                           4'd9, 40'h9999999999, 8'h00, 4'd0));
    send_operands(operands(4'd7, 40'h3141592653, 8'h00, 4'd0,
                           4'd0, 40'h2000000000, 8'h20, 4'd0));
    send_operands(operands(4'd0, 40'h1000000000, 8'h01, 4'd0,
                           4'd9, 40'h0000000001, 8'h00, 4'd0));
    send_operands(operands(4'd0, 40'h1000000000, 8'h10, 4'd0,
                           4'd6, 40'h9876543219, 8'h00, 4'd0));
    // cancellation below -99
    send_operands(operands(4'd0, 40'h1000000001, 8'h99, 4'd9,
                           4'd9, 40'h1000000000, 8'h99, 4'd9));
    // unnormalized operand, negative zero exponent, all-nines sign fields
    send_operands(operands(4'd0, 40'h0000012345, 8'h03, 4'd0,
                           4'd0, 40'h0, 8'h00, 4'd9));
    send_operands(operands(4'd9, 40'h9999999999, 8'h99, 4'd9,
                           4'd9, 40'h0000000001, 8'h99, 4'd9));
    send_operands(operands(4'd0, 40'h0, 8'h00, 4'd0,
                           4'd9, 40'h4000000000, 8'h02, 4'd0));
    send_operands(operands(4'd9, 40'h0, 8'h00, 4'd0,
                           4'd0, 40'h0, 8'h00, 4'd0));

    for (int n = 0; n < RANDOM_OPS; n++) begin
      steady = (n >= 300 && n < 450);
      send_operands(rand_operands());
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
